FILE: rtl/core/jsfe_pkg.sv
// Shared types and constants for the JSON string field extractor.
// No dependencies; used by every file of the block.
`timescale 1ns / 1ps

package jsfe_pkg;

  // Scanner phases
  typedef enum logic [2:0] {
    PH_SCAN        = 3'd0,
    PH_KEY         = 3'd1,
    PH_AFTER_KEY   = 3'd2,
    PH_AFTER_COLON = 3'd3,
    PH_SKIP        = 3'd4,
    PH_VALUE       = 3'd5
  } phase_t;

  // Which field the current value feeds
  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_TITLE   = 2'd1,
    TGT_EXTRACT = 2'd2
  } target_t;

  // Result kinds as they appear on out_kind
  localparam logic [1:0] KIND_TITLE      = 2'd0;
  localparam logic [1:0] KIND_EXTRACT    = 2'd1;
  localparam logic [1:0] KIND_LINE_END   = 2'd2;
  localparam logic [1:0] KIND_TITLE_DONE = 2'd3;

  // Characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_U  = 8'h75;

  // Wanted keys
  localparam int unsigned TITLE_LEN   = 5;
  localparam int unsigned EXTRACT_LEN = 7;
  localparam logic [0:TITLE_LEN-1][7:0]   TITLE_WORD   = "title";
  localparam logic [0:EXTRACT_LEN-1][7:0] EXTRACT_WORD = "extract";
  localparam logic [3:0] KEY_LEN_MAX = 4'd15;

  // UTF-8 encoding constants
  localparam logic [15:0] UTF_LIM1  = 16'h0080;
  localparam logic [15:0] UTF_LIM2  = 16'h0800;
  localparam logic [7:0]  UTF_CONT  = 8'h80;
  localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
  localparam logic [5:0]  UTF_MASK  = 6'h3F;

  // All results caused by one input byte; cnt is 1..3 once queued
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][1:0] kinds;
    logic [2:0][7:0] bytes;
  } bundle_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: rtl/core/jsfe_front.sv
// Front end: JSON scanner, key matcher and string value decoder.
// Builds one result bundle per accepted byte. Depends on jsfe_pkg.
`timescale 1ns / 1ps

module jsfe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  output logic              push,
  output jsfe_pkg::bundle_t bundle
);

  typedef enum logic [1:0] {
    V_NONE  = 2'd0,
    V_ONE   = 2'd1,
    V_UNI   = 2'd2,
    V_CLOSE = 2'd3
  } vact_t;

  jsfe_pkg::phase_t  phase_r, phase_nxt;
  jsfe_pkg::target_t tgt_r, tgt_nxt;
  logic        esc_r, esc_nxt;
  logic [3:0]  klen_r, klen_nxt;
  logic        may_t_r, may_t_nxt;
  logic        may_e_r, may_e_nxt;
  logic [2:0]  hx_r, hx_nxt;
  logic        uni_r, uni_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        ln_r, ln_nxt;

  logic        is_sp;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp;
  logic        t_hit, e_hit;
  vact_t       vact;
  logic [7:0]  one_byte;
  logic [1:0]  uni_cnt;
  logic [2:0][7:0] uni_bytes;

  // Character classes
  always_comb begin
    is_sp   = (in_byte == jsfe_pkg::CH_SPACE) ||
              (in_byte >= jsfe_pkg::CH_TAB && in_byte <= jsfe_pkg::CH_CR);
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_val = 4'(in_byte[2:0] + 3'd1) + 4'd8;
    end else begin
      hex_ok = 1'b0;
    end
    t_hit = (klen_r < 4'(jsfe_pkg::TITLE_LEN)) &&
            (jsfe_pkg::TITLE_WORD[klen_r[2:0]] == in_byte);
    e_hit = (klen_r < 4'(jsfe_pkg::EXTRACT_LEN)) &&
            (jsfe_pkg::EXTRACT_WORD[klen_r[2:0]] == in_byte);
  end

  // Value-phase decode and UTF-8 encoding of a finished \u escape
  always_comb begin
    vact     = V_NONE;
    one_byte = in_byte;
    if (uni_r) begin
      if (hex_ok && hx_r == 3'd3) vact = V_UNI;
    end else if (esc_r) begin
      if (in_byte != jsfe_pkg::CH_LC_U) vact = V_ONE;
      if (in_byte == jsfe_pkg::CH_LC_N) one_byte = jsfe_pkg::CH_LF;
      else if (in_byte == jsfe_pkg::CH_LC_R) one_byte = jsfe_pkg::CH_CR;
      else if (in_byte == jsfe_pkg::CH_LC_T) one_byte = jsfe_pkg::CH_TAB;
    end else if (in_byte == jsfe_pkg::CH_QUOTE) begin
      vact = V_CLOSE;
    end else if (in_byte != jsfe_pkg::CH_BSL) begin
      vact = V_ONE;
    end

    cp = {acc_r[11:0], hex_val};
    uni_bytes = '0;
    if (cp < jsfe_pkg::UTF_LIM1) begin
      uni_cnt      = 2'd1;
      uni_bytes[0] = cp[7:0];
    end else if (cp < jsfe_pkg::UTF_LIM2) begin
      uni_cnt      = 2'd2;
      uni_bytes[0] = jsfe_pkg::UTF_LEAD2 | {3'd0, cp[10:6]};
      uni_bytes[1] = jsfe_pkg::UTF_CONT | {2'd0, cp[5:0] & jsfe_pkg::UTF_MASK};
    end else begin
      uni_cnt      = 2'd3;
      uni_bytes[0] = jsfe_pkg::UTF_LEAD3 | {4'd0, cp[15:12]};
      uni_bytes[1] = jsfe_pkg::UTF_CONT | {2'd0, cp[11:6] & jsfe_pkg::UTF_MASK};
      uni_bytes[2] = jsfe_pkg::UTF_CONT | {2'd0, cp[5:0] & jsfe_pkg::UTF_MASK};
    end
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    tgt_nxt   = tgt_r;
    esc_nxt   = esc_r;
    klen_nxt  = klen_r;
    may_t_nxt = may_t_r;
    may_e_nxt = may_e_r;
    hx_nxt    = hx_r;
    uni_nxt   = uni_r;
    acc_nxt   = acc_r;
    ln_nxt    = ln_r;
    if (accept) begin
      unique case (phase_r)
        jsfe_pkg::PH_KEY: begin
          if (!esc_r && in_byte == jsfe_pkg::CH_BSL) begin
            esc_nxt = 1'b1;
          end else if (!esc_r && in_byte == jsfe_pkg::CH_QUOTE) begin
            phase_nxt = jsfe_pkg::PH_AFTER_KEY;
          end else begin
            esc_nxt = 1'b0;
            if (!t_hit) may_t_nxt = 1'b0;
            if (!e_hit) may_e_nxt = 1'b0;
            if (klen_r != jsfe_pkg::KEY_LEN_MAX) klen_nxt = klen_r + 4'd1;
          end
        end
        jsfe_pkg::PH_AFTER_KEY: begin
          if (!is_sp) begin
            phase_nxt = (in_byte == jsfe_pkg::CH_COLON) ? jsfe_pkg::PH_AFTER_COLON
                                                        : jsfe_pkg::PH_SCAN;
          end
        end
        jsfe_pkg::PH_AFTER_COLON: begin
          if (!is_sp) begin
            if (in_byte == jsfe_pkg::CH_QUOTE) begin
              esc_nxt = 1'b0;
              uni_nxt = 1'b0;
              hx_nxt  = 3'd0;
              acc_nxt = 16'd0;
              ln_nxt  = 1'b0;
              if (may_t_r && klen_r == 4'(jsfe_pkg::TITLE_LEN)) begin
                tgt_nxt   = jsfe_pkg::TGT_TITLE;
                phase_nxt = jsfe_pkg::PH_VALUE;
              end else if (may_e_r && klen_r == 4'(jsfe_pkg::EXTRACT_LEN)) begin
                tgt_nxt   = jsfe_pkg::TGT_EXTRACT;
                phase_nxt = jsfe_pkg::PH_VALUE;
              end else begin
                tgt_nxt   = jsfe_pkg::TGT_NONE;
                phase_nxt = jsfe_pkg::PH_SKIP;
              end
            end else begin
              phase_nxt = jsfe_pkg::PH_SCAN;
            end
          end
        end
        jsfe_pkg::PH_SKIP: begin
          if (esc_r) esc_nxt = 1'b0;
          else if (in_byte == jsfe_pkg::CH_BSL) esc_nxt = 1'b1;
          else if (in_byte == jsfe_pkg::CH_QUOTE) phase_nxt = jsfe_pkg::PH_SCAN;
        end
        jsfe_pkg::PH_VALUE: begin
          if (uni_r) begin
            // bad digit or fourth digit both end the sequence
            if (!hex_ok || hx_r == 3'd3) begin
              uni_nxt = 1'b0;
              hx_nxt  = 3'd0;
              acc_nxt = 16'd0;
              if (hex_ok && tgt_r == jsfe_pkg::TGT_EXTRACT) ln_nxt = 1'b1;
            end else begin
              acc_nxt = cp;
              hx_nxt  = hx_r + 3'd1;
            end
          end else if (esc_r) begin
            esc_nxt = 1'b0;
            if (in_byte == jsfe_pkg::CH_LC_U) begin
              uni_nxt = 1'b1;
              hx_nxt  = 3'd0;
              acc_nxt = 16'd0;
            end
          end else if (in_byte == jsfe_pkg::CH_BSL) begin
            esc_nxt = 1'b1;
          end else if (in_byte == jsfe_pkg::CH_QUOTE) begin
            ln_nxt    = 1'b0;
            phase_nxt = jsfe_pkg::PH_SCAN;
          end
          if (vact == V_ONE && tgt_r == jsfe_pkg::TGT_EXTRACT) begin
            ln_nxt = (one_byte != jsfe_pkg::CH_LF);
          end
        end
        default: begin
          if (in_byte == jsfe_pkg::CH_QUOTE) begin
            klen_nxt  = 4'd0;
            may_t_nxt = 1'b1;
            may_e_nxt = 1'b1;
            phase_nxt = jsfe_pkg::PH_KEY;
          end
        end
      endcase
    end
  end

  // Result bundle for this byte
  always_comb begin
    bundle = '0;
    if (accept && phase_r == jsfe_pkg::PH_VALUE) begin
      unique case (vact)
        V_ONE: begin
          if (tgt_r == jsfe_pkg::TGT_TITLE) begin
            bundle.cnt      = 2'd1;
            bundle.kinds[0] = jsfe_pkg::KIND_TITLE;
            bundle.bytes[0] = one_byte;
          end else if (tgt_r == jsfe_pkg::TGT_EXTRACT) begin
            bundle.cnt = 2'd1;
            if (one_byte == jsfe_pkg::CH_LF) begin
              bundle.kinds[0] = jsfe_pkg::KIND_LINE_END;
            end else begin
              bundle.kinds[0] = jsfe_pkg::KIND_EXTRACT;
              bundle.bytes[0] = one_byte;
            end
          end
        end
        V_UNI: begin
          if (tgt_r == jsfe_pkg::TGT_TITLE || tgt_r == jsfe_pkg::TGT_EXTRACT) begin
            bundle.cnt   = uni_cnt;
            bundle.bytes = uni_bytes;
            for (int i = 0; i < 3; i++) begin
              bundle.kinds[i] = (tgt_r == jsfe_pkg::TGT_TITLE) ? jsfe_pkg::KIND_TITLE
                                                               : jsfe_pkg::KIND_EXTRACT;
            end
          end
        end
        V_CLOSE: begin
          if (tgt_r == jsfe_pkg::TGT_TITLE) begin
            bundle.cnt      = 2'd1;
            bundle.kinds[0] = jsfe_pkg::KIND_TITLE_DONE;
          end else if (tgt_r == jsfe_pkg::TGT_EXTRACT && ln_r) begin
            bundle.cnt      = 2'd1;
            bundle.kinds[0] = jsfe_pkg::KIND_LINE_END;
          end
        end
        default: bundle = '0;
      endcase
    end
    push = (bundle.cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jsfe_pkg::PH_SCAN;
      tgt_r   <= jsfe_pkg::TGT_NONE;
      esc_r   <= 1'b0;
      klen_r  <= 4'd0;
      may_t_r <= 1'b1;
      may_e_r <= 1'b1;
      hx_r    <= 3'd0;
      uni_r   <= 1'b0;
      acc_r   <= 16'd0;
      ln_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      tgt_r   <= tgt_nxt;
      esc_r   <= esc_nxt;
      klen_r  <= klen_nxt;
      may_t_r <= may_t_nxt;
      may_e_r <= may_e_nxt;
      hx_r    <= hx_nxt;
      uni_r   <= uni_nxt;
      acc_r   <= acc_nxt;
      ln_r    <= ln_nxt;
    end
  end

endmodule

FILE: rtl/core/jsfe_queue.sv
// Short bundle queue between scanner front end and output back end.
// Depends on jsfe_pkg for the bundle and status types.
`timescale 1ns / 1ps

module jsfe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jsfe_pkg::bundle_t wdata,
  input  logic              pop,
  output jsfe_pkg::bundle_t rdata,
  output jsfe_pkg::qstat_t  stat
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jsfe_pkg::bundle_t slots [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  assign rdata      = slots[rd_ptr_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/jsfe_back.sv
// Back end: holds one bundle in the output register and hands out its
// results one beat at a time. Depends on jsfe_pkg.
`timescale 1ns / 1ps

module jsfe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  jsfe_pkg::bundle_t q_head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_byte,
  output logic [1:0]        out_kind,
  output logic              out_last
);

  jsfe_pkg::bundle_t bun_r, bun_nxt;
  logic       have_r, have_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       fire, lastbeat;

  always_comb begin
    fire     = have_r && out_pop;
    lastbeat = (2'(idx_r + 2'd1) == bun_r.cnt);
    q_pop    = !q_empty && (!have_r || (fire && lastbeat));
    bun_nxt  = q_pop ? q_head : bun_r;
    if (q_pop) begin
      have_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (fire) begin
      have_nxt = !lastbeat;
      idx_nxt  = idx_r + 2'd1;
    end else begin
      have_nxt = have_r;
      idx_nxt  = idx_r;
    end
  end

  assign out_empty = !have_r;
  assign out_byte  = bun_r.bytes[idx_r];
  assign out_kind  = bun_r.kinds[idx_r];
  assign out_last  = lastbeat;

  always_ff @(posedge clk) begin
    bun_r <= bun_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      have_r <= have_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

FILE: rtl/core/json_string_field_extractor.sv
// JSON string field extractor, top level.
// Instantiates jsfe_front, jsfe_queue and jsfe_back; depends on jsfe_pkg.
//
// Usage:
//  - Input channel: drive in_byte with the next raw document byte and raise
//    in_push; the beat is taken at a clock edge with in_push high and
//    in_full low. One byte per cycle is taken while the queue has room.
//  - Result channel: while out_empty is low, out_byte/out_kind/out_last show
//    the oldest result; it is taken at an edge with out_pop high. Kinds:
//    0 title byte, 1 extract byte, 2 extract line end, 3 title done.
//    out_last marks the final result caused by one input byte.
//  - Each input byte yields zero to three results. A byte with no result
//    never enters the queue and costs nothing beyond its input beat.
//  - Path: a byte's bundle is written into the queue at the edge that takes
//    its beat, then loaded into the output register once that is free; only
//    from there can its first result be popped.
//  - Throughput: one input byte per cycle while the queue is not full;
//    output drains one result per cycle while out_pop is high, so a
//    three-byte UTF-8 burst holds the output register for three pops.
//  - When the receiver stalls, up to QUEUE_DEPTH result bundles collect in
//    the queue plus one in the output register; then in_full rises.
//  - Reset (rst_n low, synchronous) empties queue and output and returns the
//    scanner to looking for a key.
`timescale 1ns / 1ps

module json_string_field_extractor #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last
);

  jsfe_pkg::bundle_t f_bundle;
  jsfe_pkg::bundle_t q_head;
  jsfe_pkg::qstat_t  q_stat;
  logic              f_push;
  logic              q_pop;
  logic              in_accept;

  // Front only stalls on a full queue; zero-result bytes never enter it.
  assign in_full   = q_stat.full;
  assign in_accept = in_push && !q_stat.full;

  jsfe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_byte (in_byte),
    .push    (f_push),
    .bundle  (f_bundle)
  );

  jsfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_bundle),
    .pop   (q_pop),
    .rdata (q_head),
    .stat  (q_stat)
  );

  // Back end serializes a bundle; it reloads on the last beat's pop, or whenever it holds none.
  jsfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_stat.empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(f_push && q_stat.full))
    else $error("bundle written into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_stat.empty))
    else $error("bundle read from empty queue");

  a_queued_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty |=> !out_empty)
    else $error("queued bundle not presented at output");

  a_pushed_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    f_push |-> (f_bundle.cnt != 2'd0))
    else $error("empty bundle pushed");
`endif

endmodule
